// ----- rtl/core/itd_pkg.sv -----
// shared types, constants and helpers for the integer to radix digits block
package itd_pkg;

    // conversion sequencer states
    typedef enum logic [2:0] {
        B_IDLE,
        B_START,
        B_DIV,
        B_DECIDE,
        B_EMIT
    } t_back_state;

    // result status codes
    localparam logic [1:0] ST_CHAR     = 2'd0;
    localparam logic [1:0] ST_OVERFLOW = 2'd1;
    localparam logic [1:0] ST_MEASURE  = 2'd2;

    // limits of the inputs
    localparam logic [5:0] RADIX_MIN = 6'd2;
    localparam logic [5:0] RADIX_MAX = 6'd36;
    localparam logic [5:0] RADIX_DEC = 6'd10;
    localparam logic [6:0] TEXT_MAX  = 7'd64;

    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_UPPER = 8'h41;

    // long division works on the magnitude one byte per cycle
    localparam int CHUNK_BITS = 8;

    localparam int JOB_DEPTH = 2;
    localparam int OUT_DEPTH = 2;

    // classified job control fields
    typedef struct packed {
        logic [5:0] radix;
        logic [6:0] cap;
        logic       measure;
        logic       minus;
        logic       pow2;
        logic [2:0] shift;
    } t_job_ctl;

    // one result transaction
    typedef struct packed {
        logic [7:0] char_code;
        logic [1:0] status;
        logic [6:0] text_width;
        logic       last;
    } t_out;

    // digit value to ascii, 0-9 then A-Z
    function automatic logic [7:0] digit_char(input logic [5:0] d);
        logic [7:0] c;
        if (d < 6'd10) begin
            c = CHAR_ZERO + {2'b00, d};
        end else begin
            c = CHAR_UPPER + {2'b00, d} - 8'd10;
        end
        return c;
    endfunction

endpackage

// ----- rtl/core/integer_to_radix_digits.sv -----
// top level: integer to ascii digit string converter in radix 2 to 36
// flow: front holding register, job queue, back sequencer; radix 2/4/8/16/32 digits come
// by mask and shift, others by long division (one quotient byte per cycle in the divider),
// then a decision state, and the characters are read back from the digit buffer
// throughput: one request in the digit unit at a time
// reset: synchronous active low, clears the queues and the sequencer; the buffer is not cleared
module integer_to_radix_digits
    import itd_pkg::*;
#(
    parameter int VALUE_BITS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [63:0] i_value,
    input  logic        i_mode,
    input  logic [5:0]  i_radix,
    input  logic [6:0]  i_capacity,
    input  logic        i_measure_only,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_char_code,
    output logic [1:0]  o_status,
    output logic [6:0]  o_text_width,
    output logic        o_last
);

    localparam int JOB_W = VALUE_BITS + $bits(t_job_ctl);
    localparam int JC_W  = $clog2(JOB_DEPTH + 1);

    logic                  f_valid;
    logic [VALUE_BITS-1:0] f_mag;
    t_job_ctl              f_ctl;
    logic                  q_full;
    logic                  q_valid;
    logic [JOB_W-1:0]      q_data;
    logic [JC_W-1:0]       q_count;
    logic                  q_pop;
    logic [VALUE_BITS-1:0] b_mag;
    t_job_ctl              b_ctl;

    // request intake and classification
    itd_front #(
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_value        (i_value),
        .i_mode         (i_mode),
        .i_radix        (i_radix),
        .i_capacity     (i_capacity),
        .i_measure_only (i_measure_only),
        .o_job_valid    (f_valid),
        .o_job_mag      (f_mag),
        .o_job_ctl      (f_ctl),
        .i_job_full     (q_full)
    );

    // job queue between front and back
    itd_queue #(
        .WIDTH (JOB_W),
        .DEPTH (JOB_DEPTH)
    ) u_job_q (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (f_valid),
        .i_wr_data  ({f_mag, f_ctl}),
        .o_full     (q_full),
        .o_rd_valid (q_valid),
        .o_rd_data  (q_data),
        .i_rd_en    (q_pop),
        .o_count    (q_count)
    );

    assign b_mag = q_data[JOB_W-1 -: VALUE_BITS];
    assign b_ctl = t_job_ctl'(q_data[$bits(t_job_ctl)-1:0]);

    // digit generation and emission
    itd_back #(
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job_valid  (q_valid),
        .i_job_mag    (b_mag),
        .i_job_ctl    (b_ctl),
        .o_job_pop    (q_pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_char_code  (o_char_code),
        .o_status     (o_status),
        .o_text_width (o_text_width),
        .o_last       (o_last)
    );

`ifndef SYNTHESIS
    a_job_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_count <= JC_W'(JOB_DEPTH)))
        else $error("job queue count out of range");

    a_pop_needs_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("job taken from empty queue");

    a_front_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (f_valid && q_full) |=> f_valid)
        else $error("classified job dropped while queue full");
`endif

endmodule

// ----- rtl/core/itd_ram.sv -----
// generic simple dual port ram with registered read
module itd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/core/itd_queue.sv -----
// small register fifo used between front and back and at the output
module itd_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_wr_valid,
    input  logic [WIDTH-1:0]           i_wr_data,
    output logic                       o_full,
    output logic                       o_rd_valid,
    output logic [WIDTH-1:0]           o_rd_data,
    input  logic                       i_rd_en,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_count, n_count;
    logic             push;
    logic             pop;

    assign o_full     = (r_count == CNT_W'(DEPTH));
    assign o_rd_valid = (r_count != '0);
    assign o_rd_data  = r_mem[r_rd];
    assign o_count    = r_count;

    assign push = i_wr_valid && !o_full;
    assign pop  = o_rd_valid && i_rd_en;

    // pointer and count update
    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
        end
        if (pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
        end
        if (push && !pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (pop && !push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_wr_data;
        end
    end

endmodule

// ----- rtl/core/itd_front.sv -----
// front end: accepts requests, saturates fields and classifies the conversion
module itd_front
    import itd_pkg::*;
#(
    parameter int VALUE_BITS = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [63:0]           i_value,
    input  logic                  i_mode,
    input  logic [5:0]            i_radix,
    input  logic [6:0]            i_capacity,
    input  logic                  i_measure_only,
    output logic                  o_job_valid,
    output logic [VALUE_BITS-1:0] o_job_mag,
    output t_job_ctl              o_job_ctl,
    input  logic                  i_job_full
);

    logic                  r_valid, n_valid;
    logic [VALUE_BITS-1:0] r_mag;
    t_job_ctl              r_ctl;
    logic                  accept;
    logic [VALUE_BITS-1:0] val;
    logic [VALUE_BITS-1:0] mag_c;
    t_job_ctl              ctl_c;

    assign o_stall = r_valid && i_job_full;
    assign accept  = i_valid && !o_stall;
    assign val     = i_value[VALUE_BITS-1:0];

    // field saturation and classification
    always_comb begin
        ctl_c = '0;
        if (i_radix < RADIX_MIN) begin
            ctl_c.radix = RADIX_MIN;
        end else if (i_radix > RADIX_MAX) begin
            ctl_c.radix = RADIX_MAX;
        end else begin
            ctl_c.radix = i_radix;
        end
        ctl_c.cap     = (i_capacity > TEXT_MAX) ? TEXT_MAX : i_capacity;
        ctl_c.measure = i_measure_only;
        // only a signed negative decimal value gets a minus sign
        ctl_c.minus   = i_mode && val[VALUE_BITS-1] && (ctl_c.radix == RADIX_DEC);
        ctl_c.pow2    = (ctl_c.radix inside {6'd2, 6'd4, 6'd8, 6'd16, 6'd32});
        case (ctl_c.radix)
            6'd2:    ctl_c.shift = 3'd1;
            6'd4:    ctl_c.shift = 3'd2;
            6'd8:    ctl_c.shift = 3'd3;
            6'd16:   ctl_c.shift = 3'd4;
            6'd32:   ctl_c.shift = 3'd5;
            default: ctl_c.shift = 3'd0;
        endcase
        mag_c = ctl_c.minus ? (~val + VALUE_BITS'(1)) : val;
    end

    // holding stage valid
    always_comb begin
        if (accept) begin
            n_valid = 1'b1;
        end else begin
            n_valid = r_valid && i_job_full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // classified job payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mag <= mag_c;
            r_ctl <= ctl_c;
        end
    end

    assign o_job_valid = r_valid;
    assign o_job_mag   = r_mag;
    assign o_job_ctl   = r_ctl;

endmodule

// ----- rtl/core/itd_back.sv -----
// back end: digit generation by repeated division, then reversed emission
module itd_back
    import itd_pkg::*;
#(
    parameter int VALUE_BITS = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_job_valid,
    input  logic [VALUE_BITS-1:0] i_job_mag,
    input  t_job_ctl              i_job_ctl,
    output logic                  o_job_pop,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [7:0]            o_char_code,
    output logic [1:0]            o_status,
    output logic [6:0]            o_text_width,
    output logic                  o_last
);

    localparam int NCH   = (VALUE_BITS + CHUNK_BITS - 1) / CHUNK_BITS;
    localparam int MAG_W = NCH * CHUNK_BITS;
    localparam int IDX_W = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int A_W   = $clog2(VALUE_BITS);
    localparam int N_W   = $clog2(VALUE_BITS + 1);
    localparam int OC_W  = $clog2(OUT_DEPTH + 1);

    t_back_state r_state, n_state;

    logic [MAG_W-1:0] r_mag;
    t_job_ctl         r_ctl;
    logic [IDX_W-1:0] r_idx;
    logic [5:0]       r_rem;
    logic [N_W-1:0]   r_nd;
    logic [6:0]       r_width;
    logic [A_W-1:0]   r_ptr;
    logic             r_infl;
    logic             r_infl_last;
    logic [6:0]       r_infl_width;

    logic [IDX_W-1:0]      top_idx;
    logic [CHUNK_BITS-1:0] chunk_in;
    logic [CHUNK_BITS-1:0] quot_chunk;
    logic [5:0]            div_rem;
    logic [6:0]            trial;
    logic [MAG_W-1:0]      mag_div;
    logic [MAG_W-1:0]      mag_shift;
    logic [5:0]            pow_digit;
    logic [6:0]            width_c;
    logic                  fail_c;

    logic           wr_en;
    logic [7:0]     wr_data;
    logic           rd_en;
    logic [7:0]     rd_data;
    logic           out_push;
    logic           out_pop;
    t_out           out_item;
    t_out           out_head;
    logic           out_full;
    logic [OC_W-1:0] out_count;
    logic           credit_ok;
    logic           direct_ok;

    // highest nonzero byte of the running quotient
    always_comb begin
        top_idx = '0;
        for (int k = 0; k < NCH; k++) begin
            if (|r_mag[k*CHUNK_BITS +: CHUNK_BITS]) begin
                top_idx = IDX_W'(k);
            end
        end
    end

    // one byte of restoring division by the radix
    always_comb begin
        chunk_in   = r_mag[int'(r_idx)*CHUNK_BITS +: CHUNK_BITS];
        div_rem    = r_rem;
        quot_chunk = '0;
        trial      = '0;
        for (int j = CHUNK_BITS - 1; j >= 0; j--) begin
            trial = {div_rem, chunk_in[j]};
            if (trial >= {1'b0, r_ctl.radix}) begin
                quot_chunk[j] = 1'b1;
                div_rem       = 6'(trial - {1'b0, r_ctl.radix});
            end else begin
                div_rem       = trial[5:0];
            end
        end
        mag_div = r_mag;
        mag_div[int'(r_idx)*CHUNK_BITS +: CHUNK_BITS] = quot_chunk;
    end

    // power of two radix: mask and shift
    assign pow_digit = r_mag[5:0] & (r_ctl.radix - 6'd1);
    assign mag_shift = r_mag >> r_ctl.shift;

    assign width_c = 7'(r_nd) + 7'(r_ctl.minus);
    assign fail_c  = r_ctl.measure || (width_c > r_ctl.cap);

    // output credit: queued plus in flight must leave room for one more
    assign out_pop   = o_valid && !i_stall;
    assign credit_ok = (3'(out_count) + 3'(r_infl)) < (3'(OUT_DEPTH) + 3'(out_pop));
    // a push in the same cycle needs a free entry now
    assign direct_ok = !out_full && !r_infl;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE: begin
                if (i_job_valid) begin
                    n_state = B_START;
                end
            end
            B_START: begin
                if (!r_ctl.pow2) begin
                    n_state = B_DIV;
                end else if (mag_shift == '0) begin
                    n_state = B_DECIDE;
                end
            end
            B_DIV: begin
                if (r_idx == '0) begin
                    n_state = (mag_div == '0) ? B_DECIDE : B_START;
                end
            end
            B_DECIDE: begin
                if (fail_c) begin
                    if (direct_ok) begin
                        n_state = B_IDLE;
                    end
                end else if (r_ctl.minus) begin
                    if (direct_ok) begin
                        n_state = B_EMIT;
                    end
                end else begin
                    n_state = B_EMIT;
                end
            end
            B_EMIT: begin
                if (credit_ok && (r_ptr == '0)) begin
                    n_state = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_job_pop = 1'b0;
        wr_en     = 1'b0;
        wr_data   = '0;
        rd_en     = 1'b0;
        out_push  = 1'b0;
        out_item  = '0;
        case (r_state)
            B_IDLE: begin
                o_job_pop = i_job_valid;
            end
            B_START: begin
                if (r_ctl.pow2) begin
                    wr_en   = 1'b1;
                    wr_data = digit_char(pow_digit);
                end
            end
            B_DIV: begin
                if (r_idx == '0) begin
                    wr_en   = 1'b1;
                    wr_data = digit_char(div_rem);
                end
            end
            B_DECIDE: begin
                out_item.text_width = width_c;
                if (fail_c) begin
                    out_push         = direct_ok;
                    out_item.status  = r_ctl.measure ? ST_MEASURE : ST_OVERFLOW;
                    out_item.last    = 1'b1;
                end else if (r_ctl.minus) begin
                    // at least one digit always follows the sign
                    out_push           = direct_ok;
                    out_item.char_code = CHAR_MINUS;
                    out_item.status    = ST_CHAR;
                end
            end
            B_EMIT: begin
                rd_en = credit_ok;
            end
            default: begin
                o_job_pop = 1'b0;
            end
        endcase
        // digits come back from the buffer in the cycle after the read
        if (r_infl) begin
            out_push            = 1'b1;
            out_item.char_code  = rd_data;
            out_item.status     = ST_CHAR;
            out_item.text_width = r_infl_width;
            out_item.last       = r_infl_last;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_infl  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_infl  <= rd_en;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_infl_last  <= (r_ptr == '0);
        r_infl_width <= r_width;
        case (r_state)
            B_IDLE: begin
                r_mag <= MAG_W'(i_job_mag);
                r_ctl <= i_job_ctl;
                r_nd  <= '0;
            end
            B_START: begin
                r_idx <= top_idx;
                r_rem <= '0;
                if (r_ctl.pow2) begin
                    r_mag <= mag_shift;
                    r_nd  <= r_nd + N_W'(1);
                end
            end
            B_DIV: begin
                r_mag <= mag_div;
                r_rem <= div_rem;
                r_idx <= r_idx - IDX_W'(1);
                if (r_idx == '0) begin
                    r_nd <= r_nd + N_W'(1);
                end
            end
            B_DECIDE: begin
                r_width <= width_c;
                r_ptr   <= A_W'(r_nd - N_W'(1));
            end
            B_EMIT: begin
                if (rd_en) begin
                    r_ptr <= r_ptr - A_W'(1);
                end
            end
            default: begin
                r_rem <= '0;
            end
        endcase
    end

    // digit buffer, least significant digit at address zero
    itd_ram #(
        .WIDTH (8),
        .DEPTH (VALUE_BITS)
    ) u_digits (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_nd[A_W-1:0]),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_ptr),
        .o_rd_data (rd_data)
    );

    // output skid queue
    itd_queue #(
        .WIDTH ($bits(t_out)),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (out_push),
        .i_wr_data  (out_item),
        .o_full     (out_full),
        .o_rd_valid (o_valid),
        .o_rd_data  (out_head),
        .i_rd_en    (!i_stall),
        .o_count    (out_count)
    );

    assign o_char_code  = out_head.char_code;
    assign o_status     = out_head.status;
    assign o_text_width = out_head.text_width;
    assign o_last       = out_head.last;

`ifndef SYNTHESIS
    a_rem_below_radix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_DIV) |-> (r_rem < r_ctl.radix))
        else $error("division remainder reached the radix");

    a_digit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_nd <= N_W'(VALUE_BITS)))
        else $error("digit count beyond buffer depth");

    a_read_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_infl |-> $past(r_state == B_EMIT))
        else $error("buffer read outside emission");

    a_out_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_push && !out_pop) |-> !out_full)
        else $error("output queue overrun");
`endif

endmodule
